/* src/pip_pkg.sv */
// Shared types and constants for the point_in_polygon block.
// Holds the location codes and configuration register indexes; no dependencies.
package pip_pkg;

    localparam int CFG_DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_QUERY_X = 1'b0;
    localparam logic REG_QUERY_Y = 1'b1;

    typedef enum logic [1:0] {
        LOC_OUTSIDE  = 2'd0,
        LOC_BOUNDARY = 2'd1,
        LOC_INSIDE   = 2'd2
    } loc_t;

endpackage

/* src/point_in_polygon.sv */
// Point-in-polygon classifier: crossing-number test plus exact boundary test.
// Four-stage registered pipeline; depends on pip_pkg.
//
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+--------------------------------------
// s_axis    | in  | tvalid / tready            | tdata: vertex_x, vertex_y; tlast: last
// m_axis    | out | tvalid / tready            | tdata: location
// apb       | in  | psel, penable, pwrite      | paddr: 0 query_x, 4 query_y
//
// One vertex beat per cycle unless the output stalls. A closing beat's result passes stages 1 to 3
// and the output register. A stalled output holds the whole pipeline and deasserts s_axis_tready.
// Reset clears the query point, the vertex tracking and the pipeline valid bits.
module point_in_polygon #(
    parameter int COORD_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // vertex_x [CB-1:0], vertex_y [2CB-1:CB], zero padded
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    input  logic                                     s_axis_tlast,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // location [1:0], zero padded
    output logic [7:0]                               m_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [pip_pkg::CFG_DATA_W-1:0]           pwdata,
    output logic [pip_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready
);
    import pip_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int CRW = PW + 1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [CRW-1:0] sum_t;

    // ---------------- configuration ----------------
    coord_t query_x_reg, query_y_reg;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_QUERY_X: query_x_reg <= pwdata[CW-1:0];
                REG_QUERY_Y: query_y_reg <= pwdata[CW-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_QUERY_X: prdata = CFG_DATA_W'(query_x_reg);
            REG_QUERY_Y: prdata = CFG_DATA_W'(query_y_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic out_vld_reg;
    logic adv, in_beat;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_beat       = s_axis_tvalid && adv;

    // ---------------- vertex tracking ----------------
    coord_t vx, vy;
    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic   have_first_reg;

    assign vx = s_axis_tdata[CW-1:0];
    assign vy = s_axis_tdata[2*CW-1:CW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end
        else if (in_beat)
        begin
            if (!have_first_reg)
            begin
                first_x_reg <= vx;
                first_y_reg <= vy;
            end
            prev_x_reg     <= vx;
            prev_y_reg     <= vy;
            have_first_reg <= !s_axis_tlast;
        end
    end

    // ---------------- stage 1: edge end points ----------------
    // edge 0: previous -> current, edge 1: current -> first (closing)
    logic   s1_vld_reg, s1_last_reg, s1_en0_reg;
    coord_t s1_px_reg, s1_py_reg, s1_cx_reg, s1_cy_reg, s1_fx_reg, s1_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_last_reg <= s_axis_tlast;
            s1_en0_reg  <= have_first_reg;
            s1_px_reg   <= prev_x_reg;
            s1_py_reg   <= prev_y_reg;
            s1_cx_reg   <= vx;
            s1_cy_reg   <= vy;
            s1_fx_reg   <= have_first_reg ? first_x_reg : vx;
            s1_fy_reg   <= have_first_reg ? first_y_reg : vy;
        end
    end

    // ---------------- stage 2: relative vectors and products ----------------
    diff_t ax0, ay0, bx0, by0, ax1, ay1, bx1, by1;

    assign ax0 = {s1_px_reg[CW-1], s1_px_reg} - {query_x_reg[CW-1], query_x_reg};
    assign ay0 = {s1_py_reg[CW-1], s1_py_reg} - {query_y_reg[CW-1], query_y_reg};
    assign bx0 = {s1_cx_reg[CW-1], s1_cx_reg} - {query_x_reg[CW-1], query_x_reg};
    assign by0 = {s1_cy_reg[CW-1], s1_cy_reg} - {query_y_reg[CW-1], query_y_reg};
    assign ax1 = bx0;
    assign ay1 = by0;
    assign bx1 = {s1_fx_reg[CW-1], s1_fx_reg} - {query_x_reg[CW-1], query_x_reg};
    assign by1 = {s1_fy_reg[CW-1], s1_fy_reg} - {query_y_reg[CW-1], query_y_reg};

    logic  s2_vld_reg, s2_last_reg;
    logic  [1:0] s2_en_reg, s2_apos_reg, s2_bpos_reg;
    prod_t s2_axby_reg [2];
    prod_t s2_aybx_reg [2];
    prod_t s2_axbx_reg [2];
    prod_t s2_ayby_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg    <= s1_last_reg;
            s2_en_reg      <= {s1_last_reg, s1_en0_reg};
            s2_apos_reg    <= {ay1 > 0, ay0 > 0};
            s2_bpos_reg    <= {by1 > 0, by0 > 0};
            s2_axby_reg[0] <= ax0 * by0;
            s2_aybx_reg[0] <= ay0 * bx0;
            s2_axbx_reg[0] <= ax0 * bx0;
            s2_ayby_reg[0] <= ay0 * by0;
            s2_axby_reg[1] <= ax1 * by1;
            s2_aybx_reg[1] <= ay1 * bx1;
            s2_axbx_reg[1] <= ax1 * bx1;
            s2_ayby_reg[1] <= ay1 * by1;
        end
    end

    // ---------------- stage 3: boundary and crossing per edge ----------------
    sum_t cr [2];
    sum_t dt [2];
    logic [1:0] bnd_next, tog_next;

    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            cr[e] = {s2_axby_reg[e][PW-1], s2_axby_reg[e]}
                  - {s2_aybx_reg[e][PW-1], s2_aybx_reg[e]};
            dt[e] = {s2_axbx_reg[e][PW-1], s2_axbx_reg[e]}
                  + {s2_ayby_reg[e][PW-1], s2_ayby_reg[e]};
            bnd_next[e] = s2_en_reg[e] && (cr[e] == 0) && (dt[e] <= 0);
            // upward crossing with the point left of the edge, either orientation
            tog_next[e] = s2_en_reg[e] &&
                ((!s2_apos_reg[e] && s2_bpos_reg[e] && (cr[e] > 0)) ||
                 (s2_apos_reg[e] && !s2_bpos_reg[e] && (cr[e] < 0)));
        end
    end

    logic s3_vld_reg, s3_last_reg;
    logic [1:0] s3_bnd_reg, s3_tog_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_last_reg <= s2_last_reg;
            s3_bnd_reg  <= bnd_next;
            s3_tog_reg  <= tog_next;
        end
    end

    // ---------------- stage 4: accumulate and result ----------------
    logic par_acc_reg, bnd_acc_reg;
    logic par_all, bnd_all, out_vld_next;
    loc_t loc_reg, loc_next;

    assign par_all      = par_acc_reg ^ s3_tog_reg[0] ^ s3_tog_reg[1];
    assign bnd_all      = bnd_acc_reg | s3_bnd_reg[0] | s3_bnd_reg[1];
    assign out_vld_next = s3_vld_reg && s3_last_reg;
    assign loc_next     = bnd_all ? LOC_BOUNDARY : (par_all ? LOC_INSIDE : LOC_OUTSIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_acc_reg <= 1'b0;
            bnd_acc_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= out_vld_next;
            if (s3_vld_reg)
            begin
                par_acc_reg <= s3_last_reg ? 1'b0 : par_all;
                bnd_acc_reg <= s3_last_reg ? 1'b0 : bnd_all;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && out_vld_next)
            loc_reg <= loc_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, loc_reg};

    // ---------------- assertions ----------------
    a_loc_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("invalid location code");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_vld_reg && s3_last_reg) |=> (!par_acc_reg && !bnd_acc_reg))
        else $error("accumulators not cleared after closing beat");

    a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !have_first_reg)
        else $error("polygon tracking not restarted");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(s3_vld_reg && s3_last_reg))
        else $error("result without closing beat");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for point_in_polygon: streams polygons through the vertex port,
// sets the query point over APB and checks every location beat against an internal model.
// Depends on pip_pkg and point_in_polygon.
module testbench;

    import pip_pkg::*;

    localparam int CB             = 16;
    localparam int TDATA_W        = ((2*CB+7)/8)*8;
    localparam int QUIET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENT_ITEMS  = 120;

    typedef logic signed [CB-1:0] coord_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    // vertex_x [15:0], vertex_y [31:16]
    logic [TDATA_W-1:0]    s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // location [1:0], zero padded
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    coord_t query_x = '0;
    coord_t query_y = '0;
    coord_t first_x = '0;
    coord_t first_y = '0;
    coord_t prev_x = '0;
    coord_t prev_y = '0;
    bit     have_first = 1'b0;
    bit     crossing_parity = 1'b0;
    bit     on_boundary = 1'b0;

    loc_t   polygon_locations[$];
    loc_t   want_location;
    loc_t   got_location;
    bit     failed = 1'b0;
    int     vertex_count = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    point_in_polygon #(
        .COORD_BITS(CB)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    // one edge test: boundary hit, else upward-crossing ray toggles parity
    function automatic void examine_side(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        longint ax, ay, bx, by, cr, dt, t;
        ax = longint'(sx) - longint'(query_x);
        ay = longint'(sy) - longint'(query_y);
        bx = longint'(ex) - longint'(query_x);
        by = longint'(ey) - longint'(query_y);
        cr = ax * by - ay * bx;
        dt = ax * bx + ay * by;
        if (cr == 0 && dt <= 0)
        begin
            on_boundary = 1'b1;
            return;
        end
        if (ay > by)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
            cr = -cr;
        end
        if (ay <= 0 && by > 0 && cr > 0)
            crossing_parity = !crossing_parity;
    endfunction

    function automatic void classify_vertex(coord_t vx, coord_t vy, bit last);
        if (have_first)
            examine_side(prev_x, prev_y, vx, vy);
        else
        begin
            first_x = vx;
            first_y = vy;
            have_first = 1'b1;
        end
        prev_x = vx;
        prev_y = vy;
        if (last)
        begin
            examine_side(vx, vy, first_x, first_y);
            polygon_locations.push_back(on_boundary ? LOC_BOUNDARY :
                                        (crossing_parity ? LOC_INSIDE : LOC_OUTSIDE));
            have_first = 1'b0;
            crossing_parity = 1'b0;
            on_boundary = 1'b0;
        end
    endfunction

    function automatic coord_t pick_coord(coord_t q);
        int v;
        int off;
        case ($urandom_range(3))
            0:
            begin
                off = $urandom_range(8);
                v = int'(q) + off - 4;
            end
            1:
            begin
                off = $urandom_range(600);
                v = int'(q) + off - 300;
            end
            default:
                return coord_t'($urandom);
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    task automatic send_vertex(coord_t x, coord_t y, bit last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        classify_vertex(x, y, last);
        vertex_count++;
    endtask

    task automatic wait_until_quiet();
        s_axis_tvalid <= 1'b0;
        while (polygon_locations.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_query_reg(logic idx, coord_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_QUERY_X)
            query_x = value;
        else
            query_y = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_query(coord_t x, coord_t y);
        write_query_reg(REG_QUERY_X, x);
        write_query_reg(REG_QUERY_Y, y);
    endtask

    task automatic send_random_polygon();
        int n;
        int i;
        coord_t x0, y0, x1, y1;
        if ($urandom_range(9) < 3)
        begin
            x0 = pick_coord(query_x);
            y0 = pick_coord(query_y);
            x1 = pick_coord(query_x);
            y1 = pick_coord(query_y);
            send_vertex(x0, y0, 1'b0);
            send_vertex(x1, y0, 1'b0);
            send_vertex(x1, y1, 1'b0);
            send_vertex(x0, y1, 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                send_vertex(pick_coord(query_x), pick_coord(query_y), i == n - 1);
        end
    endtask

    task automatic pick_query_setting();
        case ($urandom_range(3))
            0: set_query($urandom_range(1) ? 16'sh7fff : 16'sh8000,
                         $urandom_range(1) ? 16'sh7fff : 16'sh8000);
            1: set_query('0, '0);
            default: set_query(coord_t'($urandom), coord_t'($urandom));
        endcase
    endtask

    task automatic run_random_phase(int src_pct, int sink_pct, int target);
        int start_count;
        int segment_end;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start_count    = vertex_count;
        while (vertex_count - start_count < target)
        begin
            pick_query_setting();
            segment_end = vertex_count + SEGMENT_ITEMS;
            while (vertex_count < segment_end)
                send_random_polygon();
            wait_until_quiet();
        end
    endtask

    // single vertex, inside square, point on edge, outside triangle
    task automatic test_basic_shapes();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(16'sd3, -16'sd7, 1'b1);
        send_vertex(-16'sd10, -16'sd10, 1'b0);
        send_vertex(16'sd10, -16'sd10, 1'b0);
        send_vertex(16'sd10, 16'sd10, 1'b0);
        send_vertex(-16'sd10, 16'sd10, 1'b1);
        send_vertex(-16'sd5, 16'sd0, 1'b0);
        send_vertex(16'sd5, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd5, 1'b1);
        send_vertex(16'sd10, 16'sd10, 1'b0);
        send_vertex(16'sd20, 16'sd10, 1'b0);
        send_vertex(16'sd15, 16'sd20, 1'b1);
        wait_until_quiet();
    endtask

    task automatic test_extreme_coords();
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(16'sd0, 16'sh7fff, 1'b1);
        wait_until_quiet();
        set_query(16'sh7fff, 16'sh8000);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
        send_vertex(16'sh8000, 16'sh7fff, 1'b1);
        wait_until_quiet();
    endtask

    // query moves while a polygon is open; only later edges see it
    task automatic test_query_rewrite_midway();
        set_query('0, '0);
        send_vertex(-16'sd10, -16'sd10, 1'b0);
        send_vertex(16'sd10, -16'sd10, 1'b0);
        wait_until_quiet();
        set_query(16'sd100, 16'sd100);
        send_vertex(16'sd10, 16'sd10, 1'b0);
        send_vertex(-16'sd10, 16'sd10, 1'b1);
        wait_until_quiet();
    endtask

    task automatic test_backpressure();
        int start_count;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_query(16'sh8000, 16'sh7fff);
        start_count = vertex_count;
        hold_left = 300;
        while (vertex_count - start_count < 60)
            send_random_polygon();
        wait_until_quiet();
    endtask

    task automatic test_random_no_idle();
        run_random_phase(0, 0, 470);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(80, 0, 470);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(0, 80, 470);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(34, 34, 470);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_location = loc_t'(m_axis_tdata[1:0]);
            if (polygon_locations.size() == 0)
            begin
                $error("location: unexpected beat, actual %0d", got_location);
                failed = 1'b1;
            end
            else
            begin
                want_location = polygon_locations.pop_front();
                if (got_location != want_location)
                begin
                    $error("location: expected %0d, actual %0d", want_location, got_location);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_shapes();
        test_extreme_coords();
        test_query_rewrite_midway();
        test_backpressure();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        wait_until_quiet();
        if (!failed && polygon_locations.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
src/pip_pkg.sv
src/point_in_polygon.sv
sim/testbench.sv
